>>> sv/mpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_pkg
// shared constants, codes and types of the max priority queue
// ----------------------------------------------------------------------------
package mpq_pkg;

  // number of cells in the chain
  localparam int unsigned Depth    = 64;
  // width of the internal entry count
  localparam int unsigned CntW     = $clog2(Depth + 1);
  // fixed field widths
  localparam int unsigned KeyW     = 32;
  localparam int unsigned CapW     = 7;
  localparam int unsigned CountW   = 7;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned OutDataW = 40;

  localparam logic [CapW-1:0]  CapReset = CapW'(64);
  localparam logic [KeyW-1:0]  SignBit  = {1'b1, {(KeyW-1){1'b0}}};

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // command broadcast to every cell
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [KeyW-1:0] key;
  } cell_cmd_t;

endpackage

>>> sv/mpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_cell
// one slot of the sorted chain, largest key at the head
// ----------------------------------------------------------------------------
module mpq_cell import mpq_pkg::*; (
  input  logic            clk_i,
  input  cell_cmd_t       cmd_i,
  input  logic            occ_i,       // slot holds a live entry
  input  logic [KeyW-1:0] prev_key_i,  // key of the neighbor toward the head
  input  logic            prev_gt_i,   // new key beats the neighbor toward the head
  input  logic [KeyW-1:0] next_key_i,  // key of the neighbor toward the tail
  output logic [KeyW-1:0] key_o,
  output logic            gt_o
);

  logic [KeyW-1:0] key_q, key_d;

  // an empty slot counts as smaller than anything
  assign gt_o  = !occ_i || (cmd_i.key > key_q);
  assign key_o = key_q;

  always_comb begin
    key_d = key_q;
    if (cmd_i.ins) begin
      if (gt_o) begin
        key_d = prev_gt_i ? prev_key_i : cmd_i.key;
      end
    end else if (cmd_i.rem) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

>>> sv/max_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_priority_queue
// max priority queue of signed 32-bit priorities built as a chain of cells
// ----------------------------------------------------------------------------
// The queue takes one word per clock cycle while results are taken, either an
// insert or a remove-maximum, and hands back exactly one result word for each,
// registered in the cycle after acceptance. The entries live in a row of Depth
// cells kept in descending order, head first. An insert is compared against
// every cell at once and each cell either keeps its key, takes the new key, or
// takes its head-side neighbor's key, so the row stays sorted. A remove reads
// the head and shifts every cell one step toward the head. The rate is therefore
// one word per cycle, set by the cell update; the one result register only stalls
// the input when a finished result is not being taken. The capacity register
// may only be written while the queue is idle; values above Depth saturate.
// ----------------------------------------------------------------------------
module max_priority_queue import mpq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // capacity register write
  input  logic                cfg_we_i,
  input  logic [CapW-1:0]     cfg_wdata_i,
  // operation stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [KeyW-1:0]     s_axis_tdata,   // [31:0] value
  input  logic                s_axis_tuser,   // [0] opcode
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [31:0] removed_value, [38:32] count, [39] zero
  output logic [StatusW-1:0]  m_axis_tuser    // [1:0] status
);

  logic [CapW-1:0] cap_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] limit;

  // result register
  logic                out_valid_q;
  logic [KeyW-1:0]     out_value_q, out_value_d;
  status_e             out_status_q, out_status_d;
  logic [CntW-1:0]     out_count_q;

  logic      accept;
  logic      is_remove;
  logic      ins_ok, rem_ok;
  cell_cmd_t cmd;

  logic [KeyW-1:0] key   [Depth];
  logic [Depth-1:0] gt;
  logic [Depth-1:0] occ;

  // handshake: a new word may enter whenever the result slot frees up
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_remove     = (op_e'(s_axis_tuser) == OP_REMOVE);

  // effective capacity saturates at the number of cells
  always_comb begin
    if (32'(cap_q) > 32'(Depth)) begin
      limit = CntW'(Depth);
    end else begin
      limit = CntW'(cap_q);
    end
  end

  assign ins_ok = !is_remove && (count_q < limit);
  assign rem_ok = is_remove && (count_q != '0);

  // keys are biased by the sign bit so an unsigned compare orders them
  assign cmd.ins = accept && ins_ok;
  assign cmd.rem = accept && rem_ok;
  assign cmd.key = s_axis_tdata ^ SignBit;

  // chain of cells, head is cell 0
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [KeyW-1:0] prev_key;
    logic            prev_gt;
    logic [KeyW-1:0] next_key;

    assign occ[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_key = key[0];
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_key = key[i-1];
      assign prev_gt  = gt[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign next_key = key[i];
    end else begin : g_inner
      assign next_key = key[i+1];
    end

    mpq_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occ_i      (occ[i]),
      .prev_key_i (prev_key),
      .prev_gt_i  (prev_gt),
      .next_key_i (next_key),
      .key_o      (key[i]),
      .gt_o       (gt[i])
    );
  end

  // entry count and result fields
  always_comb begin
    count_d      = count_q;
    out_value_d  = '0;
    out_status_d = ST_OK;
    if (is_remove) begin
      if (rem_ok) begin
        count_d     = count_q - CntW'(1);
        out_value_d = key[0] ^ SignBit;
      end else begin
        out_status_d = ST_EMPTY;
      end
    end else begin
      if (ins_ok) begin
        count_d = count_q + CntW'(1);
      end else begin
        out_status_d = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, CountW'(out_count_q), out_value_q};
  assign m_axis_tuser  = out_status_q;

endmodule

>>> sv/mpq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_checker
// port-level checks of the max priority queue
// ----------------------------------------------------------------------------
module mpq_checker import mpq_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [StatusW-1:0]  m_axis_tuser
);

  logic [CountW-1:0] last_count_q;
  logic [CountW-1:0] out_count;

  assign out_count = m_axis_tdata[KeyW +: CountW];

  // count reported by the last delivered word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      last_count_q <= out_count;
    end
  end

  // a remove on an empty queue reports zero value and zero count
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY)
      |-> (m_axis_tdata[KeyW-1:0] == '0) && (out_count == '0))
    else $error("empty remove with nonzero value or count");

  // a refused insert leaves the count where it was
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> (out_count == last_count_q))
    else $error("refused insert changed the count");

  // a good operation moves the count by exactly one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_OK)
      |-> (out_count == last_count_q + CountW'(1))
       || (out_count == last_count_q - CountW'(1)))
    else $error("count moved by other than one");

  // no input taken while a result stalls
  a_stall_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while result stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
      |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind max_priority_queue mpq_checker u_mpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the max priority queue
// ----------------------------------------------------------------------------
// Drives insert and remove-maximum words into the operation stream and checks
// every result word against a behavioral queue kept in the bench. A short
// table of directed words comes first, then random traffic in several phases.
// Each phase sets a capacity and an idle pattern on either stream.
// The phases cover the full and empty refusals and a capacity of zero, one and
// above the depth. One phase lowers the capacity below the held count, and
// another holds the result stream off long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;
  import mpq_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  // one result word as the block reports it
  typedef struct packed {
    logic [KeyW-1:0]   removed;
    status_e           status;
    logic [CountW-1:0] count;
  } qresult_t;

  // one operation word, with an optional hand-typed result
  typedef struct packed {
    op_e             op;
    logic [KeyW-1:0] value;
    logic            typed;
    qresult_t        want;
  } qop_t;

  // directed words: extremes of the value, both opcodes, empty queue,
  // value ignored on remove, duplicates and alternating bit patterns
  localparam qop_t DirectedOps [20] = '{
    '{OP_REMOVE, 32'hffff_ffff, 1'b1, '{32'h0000_0000, ST_EMPTY, 7'd0}},
    '{OP_INSERT, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK, 7'd1}},
    '{OP_INSERT, 32'h7fff_ffff, 1'b1, '{32'h0000_0000, ST_OK, 7'd2}},
    '{OP_INSERT, 32'h8000_0000, 1'b1, '{32'h0000_0000, ST_OK, 7'd3}},
    '{OP_INSERT, 32'hffff_ffff, 1'b1, '{32'h0000_0000, ST_OK, 7'd4}},
    '{OP_INSERT, 32'h0000_0001, 1'b1, '{32'h0000_0000, ST_OK, 7'd5}},
    '{OP_INSERT, 32'h0000_0005, 1'b0, '0},
    '{OP_INSERT, 32'h0000_0005, 1'b0, '0},
    '{OP_INSERT, 32'haaaa_aaaa, 1'b0, '0},
    '{OP_INSERT, 32'h5555_5555, 1'b0, '0},
    '{OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h7fff_ffff, ST_OK, 7'd8}},
    '{OP_REMOVE, 32'hffff_ffff, 1'b0, '0},
    '{OP_REMOVE, 32'h1234_5678, 1'b0, '0},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
    '{OP_REMOVE, 32'h8000_0000, 1'b0, '0},
    '{OP_REMOVE, 32'h7fff_ffff, 1'b0, '0},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
    '{OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h8000_0000, ST_OK, 7'd0}},
    '{OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY, 7'd0}}
  };

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // block ports
  logic                cfg_we_i    = 1'b0;
  logic [CapW-1:0]     cfg_wdata_i = '0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]  m_axis_tuser;

  // word currently offered on the operation stream
  logic op_valid = 1'b0;
  qop_t op_word  = '{OP_INSERT, 32'h0, 1'b0, '0};

  max_priority_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (op_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (op_word.value),   // [31:0] value
    .s_axis_tuser  (op_word.op),      // [0] opcode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // [31:0] removed_value, [38:32] count, [39] zero
    .m_axis_tuser  (m_axis_tuser)     // [1:0] status
  );

  // words waiting to be sent and results waiting to arrive
  qop_t     pending_ops[$];
  qresult_t awaited_results[$];

  // behavioral queue: held priorities and the capacity register
  int              held_keys[$];
  logic [CapW-1:0] cap_reg = CapReset;

  // idle pattern of the current phase, in percent
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          rx_hold        = 1'b0;
  bit          hold_request   = 1'b0;

  // handshakes seen at the falling edge before the rising edge that completes them
  bit op_fire  = 1'b0;
  bit res_fire = 1'b0;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_ins_ok = 0, n_full = 0, n_rem_ok = 0, n_empty = 0;

  // applies one operation to the behavioral queue and returns its result
  function automatic qresult_t queue_apply(op_e op, logic [KeyW-1:0] value);
    qresult_t    res;
    int unsigned limit;
    int          best;
    limit = (cap_reg > Depth) ? Depth : cap_reg;
    res   = '{'0, ST_OK, '0};
    if (op == OP_INSERT) begin
      if (held_keys.size() < limit) begin
        held_keys.push_back($signed(value));
        n_ins_ok++;
      end else begin
        res.status = ST_FULL;
        n_full++;
      end
    end else begin
      if (held_keys.size() > 0) begin
        // equal keys are interchangeable, so any copy of the max will do
        best = 0;
        for (int i = 1; i < held_keys.size(); i++) begin
          if (held_keys[i] > held_keys[best]) best = i;
        end
        res.removed = held_keys[best];
        held_keys.delete(best);
        n_rem_ok++;
      end else begin
        res.status = ST_EMPTY;
        n_empty++;
      end
    end
    res.count = CountW'(held_keys.size());
    return res;
  endfunction

  // picks a priority: extremes, a narrow band that makes duplicates, or anything
  function automatic logic [KeyW-1:0] pick_priority();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3, 4: return KeyW'($signed($urandom_range(15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // sender: a new word is put up only when the bus is free or just accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      op_valid <= 1'b0;
    end else if (!op_valid || op_fire) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        op_valid <= 1'b1;
        op_word  <= pending_ops.pop_front();
      end else begin
        op_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, or a long hold while the pressure stretch runs
  always @(posedge clk_i) begin
    if (!rst_ni || rx_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold, counted in its own process; the sender keeps going
  initial begin
    wait (hold_request);
    @(negedge clk_i);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    rx_hold = 1'b0;
  end

  // sampling at the falling edge keeps us clear of the rising-edge updates
  always @(negedge clk_i) begin
    qresult_t want;
    qresult_t got;
    op_fire  = rst_ni && op_valid && s_axis_tready;
    res_fire = rst_ni && m_axis_tvalid && m_axis_tready;
    if (op_fire) begin
      want = queue_apply(op_word.op, op_word.value);
      // hand-typed rows stand in for the prediction
      awaited_results.push_back(op_word.typed ? op_word.want : want);
    end
    if (res_fire) begin
      got.removed = m_axis_tdata[KeyW-1:0];
      got.count   = m_axis_tdata[KeyW +: CountW];
      got.status  = status_e'(m_axis_tuser);
      if (awaited_results.size() == 0) begin
        $display("%0t: result word with none awaited: value %h status %0d count %0d",
                 $realtime, got.removed, got.status, got.count);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (got.removed !== want.removed) begin
          $display("%0t: removed_value mismatch: expected %h actual %h",
                   $realtime, want.removed, got.removed);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $realtime, want.status, got.status);
          errors++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count mismatch: expected %0d actual %0d",
                   $realtime, want.count, got.count);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycles, awaited_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // random words; ins_pct steers the queue toward full or toward empty
  task automatic queue_random(int unsigned n, int unsigned ins_pct);
    qop_t w;
    for (int unsigned i = 0; i < n; i++) begin
      w       = '{OP_INSERT, pick_priority(), 1'b0, '0};
      w.op    = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
      pending_ops.push_back(w);
    end
  endtask

  task automatic queue_inserts(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      pending_ops.push_back('{OP_INSERT, pick_priority(), 1'b0, '0});
    end
  endtask

  // waits until every word is sent and every result is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || op_valid || awaited_results.size() != 0);
  endtask

  // capacity write, only ever issued while the queue is idle
  task automatic write_capacity(logic [CapW-1:0] cap);
    wait_drained();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_reg      = cap;
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table at the reset capacity, no idling
    foreach (DirectedOps[i]) pending_ops.push_back(DirectedOps[i]);

    // fill toward full while the receiver is held off
    write_capacity(CapW'(64));
    queue_random(300, 70);
    hold_request = 1'b1;

    // capacity one: full and empty back to back, sparse sender
    write_capacity(CapW'(1));
    set_idling(85, 0);
    queue_random(100, 50);

    // capacity zero refuses every insert; slow receiver
    write_capacity(CapW'(0));
    set_idling(0, 85);
    queue_random(30, 50);

    // largest register value saturates at the depth; end up completely full
    write_capacity(CapW'(127));
    set_idling(12, 12);
    queue_random(200, 55);
    queue_inserts(Depth);

    // lowered below the held count: inserts refused until removes catch up
    write_capacity(CapW'(10));
    set_idling(0, 85);
    queue_random(200, 45);

    // mixed traffic at the reset capacity, alternating idle patterns
    write_capacity(CapW'(64));
    set_idling(12, 12);
    queue_random(150, 50);
    wait_drained();
    set_idling(0, 0);
    queue_random(150, 50);

    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("covered %0d inserts taken, %0d refused as full, %0d removes, %0d on empty",
             n_ins_ok, n_full, n_rem_ok, n_empty);
    $display("capacities 64, 1, 0, 127 and 10, one long result-side hold, %0d cycles",
             cycles);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
